[sv/quaternion_alu_defines.svh]
// ----------------------------------------------------------------------------
// Quaternion ALU assertion macros
// Shared assertion wrappers. Defining SYNTH removes them.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ALU_DEFINES_SVH
`define QUATERNION_ALU_DEFINES_SVH

`ifndef SYNTH
`define QALU_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
   else $error(msg);
`define QALU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);
`else
`define QALU_ASSERT(label, cond, msg)
`define QALU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[sv/qalu_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Widths, opcodes, request/response types and Q4.12 rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package qalu_pkg;

   localparam int CompWidth = 16;
   localparam int Frac      = 12;
   localparam int SqWidth   = 33;
   localparam int RootWidth = 17;
   localparam int LenWidth  = 18;
   localparam int NrmWidth  = 21;
   localparam int NumWidth  = 29;
   localparam int DenWidth  = 22;

   localparam logic [14:0] EpsilonReset = 15'd4;
   localparam logic        CsrEpsilon   = 1'b0;

   localparam logic [CompWidth-1:0] OneQ   = 16'h1000;
   localparam logic [CompWidth-1:0] SatMax = 16'h7fff;
   localparam logic [CompWidth-1:0] SatMin = 16'h8000;

   typedef enum logic [3:0] {
      OP_MUL       = 4'd0,
      OP_DOT       = 4'd1,
      OP_LENGTH    = 4'd2,
      OP_NORM      = 4'd3,
      OP_NORMALIZE = 4'd4,
      OP_CONJUGATE = 4'd5,
      OP_INVERSE   = 4'd6,
      OP_ADD       = 4'd7,
      OP_SUB       = 4'd8,
      OP_SCALE     = 4'd9,
      OP_EQUAL     = 4'd10
   } qalu_op_type;

   typedef logic [3:0][CompWidth-1:0] qalu_quat_type;

   typedef struct packed {
      logic [3:0]                  req_type;
      logic signed [CompWidth-1:0] a_w;
      logic signed [CompWidth-1:0] a_x;
      logic signed [CompWidth-1:0] a_y;
      logic signed [CompWidth-1:0] a_z;
      logic signed [CompWidth-1:0] b_w;
      logic signed [CompWidth-1:0] b_x;
      logic signed [CompWidth-1:0] b_y;
      logic signed [CompWidth-1:0] b_z;
      logic signed [CompWidth-1:0] scale_factor;
   } qalu_req_type;

   typedef struct packed {
      logic signed [CompWidth-1:0] r_w;
      logic signed [CompWidth-1:0] r_x;
      logic signed [CompWidth-1:0] r_y;
      logic signed [CompWidth-1:0] r_z;
      logic                        is_equal;
      logic                        zero_norm_error;
   } qalu_rsp_type;

   typedef struct packed {
      logic [3:0]         op;
      qalu_quat_type      a;
      logic [SqWidth-1:0] sumsq;
      qalu_rsp_type       res;
   } qalu_ctx_type;

   function automatic logic [CompWidth-1:0] sat_wide(input logic signed [35:0] v);
      if (v > 36'sd32767) begin
         return SatMax;
      end else if (v < -36'sd32768) begin
         return SatMin;
      end
      return v[CompWidth-1:0];
   endfunction

   // round to nearest, tie toward +inf, then saturate
   function automatic logic [CompWidth-1:0] rnd_sat(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = (v + (36'sd1 <<< (Frac - 1))) >>> Frac;
      return sat_wide(t);
   endfunction

endpackage

`default_nettype wire

[sv/quaternion_alu.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU
// Q4.12 quaternion arithmetic: product, dot, length, norm, normalize,
// conjugate, inverse, add, sub, scale and equality within epsilon.
//
//   port group   handshake                       payload
//   request      start / busy                    req_data
//   response     rsp_strobe (one cycle)          rsp_data
//   csr          psel penable pwrite pready      paddr pwdata prdata
//
// One request per cycle through 52 register stages for every op; most of
// them are the 17-stage square root and the 29-stage divider.
// Synchronous reset clears all valid bits and sets epsilon to 4; busy is
// high only during reset. Responses cannot be held off and never stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_alu_defines.svh"

module quaternion_alu (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  qalu_pkg::qalu_req_type req_data,
   output logic                   rsp_strobe,
   output qalu_pkg::qalu_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import qalu_pkg::*;

   logic         busy_ff;
   logic [14:0]  epsilon_ff;
   logic         csr_write;
   logic         req_accept;
   logic         fe_valid, sq_valid;
   qalu_ctx_type fe_ctx, sq_ctx;
   logic [LenWidth-1:0] sq_len;

   assign csr_write  = psel && penable && pwrite && pready;
   assign req_accept = start && !busy;
   assign pready     = 1'b1;
   assign busy       = busy_ff;
   assign prdata     = (paddr[2] == CsrEpsilon) ? {17'b0, epsilon_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         epsilon_ff <= EpsilonReset;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write && paddr[2] == CsrEpsilon) begin
            epsilon_ff <= pwdata[14:0];
         end
      end
   end

   qalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .req       (req_data),
      .epsilon   (epsilon_ff),
      .out_valid (fe_valid),
      .out_ctx   (fe_ctx)
   );

   qalu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ctx    (fe_ctx),
      .out_valid (sq_valid),
      .out_ctx   (sq_ctx),
      .out_len   (sq_len)
   );

   qalu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ctx    (sq_ctx),
      .in_len    (sq_len),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

   `QALU_ASSERT(a_flags_exclusive, !(rsp_strobe && rsp_data.is_equal && rsp_data.zero_norm_error), "both result flags set")
   `QALU_ASSERT(a_err_zero_result, !(rsp_strobe && rsp_data.zero_norm_error) || (rsp_data.r_w == 16'h0 && rsp_data.r_x == 16'h0 && rsp_data.r_y == 16'h0 && rsp_data.r_z == 16'h0), "zero norm error with nonzero result")
   `QALU_ASSERT_NEXT(a_eps_write, csr_write && paddr[2] == CsrEpsilon, epsilon_ff == $past(pwdata[14:0]), "epsilon write lost")

endmodule

`default_nettype wire

[sv/qalu_front.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU front end
// Input register, product stage and sum/round stage for the direct ops.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  qalu_pkg::qalu_req_type req,
   input  logic [14:0]           epsilon,
   output logic                  out_valid,
   output qalu_pkg::qalu_ctx_type out_ctx
);
   import qalu_pkg::*;

   logic         s1_vld_ff, s2_vld_ff, s3_vld_ff;
   qalu_req_type s1_req_ff, s2_req_ff;
   qalu_ctx_type ctx_ff, ctx_in;

   logic signed [31:0] pm_ff [4][4];
   logic signed [31:0] sq_ff [4];
   logic signed [31:0] sc_ff [4];

   logic signed [CompWidth-1:0] a1 [4];
   logic signed [CompWidth-1:0] b1 [4];
   logic signed [CompWidth-1:0] a2 [4];
   logic signed [CompWidth-1:0] b2 [4];

   logic signed [35:0]   h [4];
   logic signed [35:0]   dot;
   logic signed [35:0]   dif;
   logic signed [35:0]   eps_s;
   logic [SqWidth-1:0]   sumsq_in;
   logic [CompWidth-1:0] r_in [4];
   logic                 eq_ok;

   assign a1[0] = s1_req_ff.a_w;
   assign a1[1] = s1_req_ff.a_x;
   assign a1[2] = s1_req_ff.a_y;
   assign a1[3] = s1_req_ff.a_z;
   assign b1[0] = s1_req_ff.b_w;
   assign b1[1] = s1_req_ff.b_x;
   assign b1[2] = s1_req_ff.b_y;
   assign b1[3] = s1_req_ff.b_z;

   assign a2[0] = s2_req_ff.a_w;
   assign a2[1] = s2_req_ff.a_x;
   assign a2[2] = s2_req_ff.a_y;
   assign a2[3] = s2_req_ff.a_z;
   assign b2[0] = s2_req_ff.b_w;
   assign b2[1] = s2_req_ff.b_x;
   assign b2[2] = s2_req_ff.b_y;
   assign b2[3] = s2_req_ff.b_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req;
      s2_req_ff <= s1_req_ff;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pm_ff[i][j] <= a1[i] * b1[j];
         end
         sq_ff[i] <= a1[i] * a1[i];
         sc_ff[i] <= a1[i] * s1_req_ff.scale_factor;
      end
      ctx_ff <= ctx_in;
   end

   always_comb begin
      h[0] = 36'(pm_ff[0][0]) - 36'(pm_ff[1][1]) - 36'(pm_ff[2][2]) - 36'(pm_ff[3][3]);
      h[1] = 36'(pm_ff[0][1]) + 36'(pm_ff[1][0]) + 36'(pm_ff[2][3]) - 36'(pm_ff[3][2]);
      h[2] = 36'(pm_ff[0][2]) - 36'(pm_ff[1][3]) + 36'(pm_ff[2][0]) + 36'(pm_ff[3][1]);
      h[3] = 36'(pm_ff[0][3]) + 36'(pm_ff[1][2]) - 36'(pm_ff[2][1]) + 36'(pm_ff[3][0]);
      dot  = 36'(pm_ff[0][0]) + 36'(pm_ff[1][1]) + 36'(pm_ff[2][2]) + 36'(pm_ff[3][3]);
      sumsq_in = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};
      eps_s = $signed({21'b0, epsilon});
      eq_ok = 1'b1;
      dif   = '0;
      for (int i = 0; i < 4; i++) begin
         r_in[i] = '0;
      end
      ctx_in.res = '0;

      unique case (s2_req_ff.req_type)
         OP_MUL: begin
            for (int i = 0; i < 4; i++) begin
               r_in[i] = rnd_sat(h[i]);
            end
         end
         OP_DOT:  r_in[0] = rnd_sat(dot);
         OP_NORM: r_in[0] = rnd_sat($signed({3'b0, sumsq_in}));
         OP_CONJUGATE: begin
            r_in[0] = a2[0];
            for (int i = 1; i < 4; i++) begin
               r_in[i] = sat_wide(-36'(a2[i]));
            end
         end
         OP_ADD: begin
            for (int i = 0; i < 4; i++) begin
               r_in[i] = sat_wide(36'(a2[i]) + 36'(b2[i]));
            end
         end
         OP_SUB: begin
            for (int i = 0; i < 4; i++) begin
               r_in[i] = sat_wide(36'(a2[i]) - 36'(b2[i]));
            end
         end
         OP_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               r_in[i] = rnd_sat(36'(sc_ff[i]));
            end
         end
         OP_EQUAL: begin
            for (int i = 0; i < 4; i++) begin
               dif = 36'(a2[i]) - 36'(b2[i]);
               if (dif > eps_s || dif < -eps_s) begin
                  eq_ok = 1'b0;
               end
            end
            ctx_in.res.is_equal = eq_ok;
         end
         default: begin
         end
      endcase

      ctx_in.res.r_w = r_in[0];
      ctx_in.res.r_x = r_in[1];
      ctx_in.res.r_y = r_in[2];
      ctx_in.res.r_z = r_in[3];
      ctx_in.op      = s2_req_ff.req_type;
      ctx_in.a[0]    = s2_req_ff.a_w;
      ctx_in.a[1]    = s2_req_ff.a_x;
      ctx_in.a[2]    = s2_req_ff.a_y;
      ctx_in.a[3]    = s2_req_ff.a_z;
      ctx_in.sumsq   = sumsq_in;
   end

   assign out_valid = s3_vld_ff;
   assign out_ctx   = ctx_ff;

endmodule

`default_nettype wire

[sv/qalu_sqrt.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU square root
// One root bit per stage over the sum of squares, then round to nearest.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_alu_defines.svh"

module qalu_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  qalu_pkg::qalu_ctx_type in_ctx,
   output logic                   out_valid,
   output qalu_pkg::qalu_ctx_type out_ctx,
   output logic [qalu_pkg::LenWidth-1:0] out_len
);
   import qalu_pkg::*;

   logic                 vld_ff  [RootWidth];
   logic [SqWidth-1:0]   rem_ff  [RootWidth];
   logic [RootWidth-1:0] root_ff [RootWidth];
   qalu_ctx_type         ctx_ff  [RootWidth];

   logic                vld_o_ff;
   qalu_ctx_type        ctx_o_ff;
   logic [LenWidth-1:0] len_ff, len_in;
   logic [33:0]         twice_root;

   for (genvar k = 0; k < RootWidth; k++) begin : g_step
      logic                 vld_prev;
      logic [SqWidth-1:0]   rem_prev;
      logic [RootWidth-1:0] root_prev;
      qalu_ctx_type         ctx_prev;
      logic [35:0]          term;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = in_ctx.sumsq;
         assign root_prev = '0;
         assign ctx_prev  = in_ctx;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign ctx_prev  = ctx_ff[k-1];
      end

      // (root + 2^i)^2 - root^2
      assign term = (36'(root_prev) << (RootWidth - k))
                  + (36'd1 << (2 * (RootWidth - 1 - k)));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         ctx_ff[k] <= ctx_prev;
         if (36'(rem_prev) >= term) begin
            rem_ff[k]  <= rem_prev - term[SqWidth-1:0];
            root_ff[k] <= root_prev | (RootWidth'(1) << (RootWidth - 1 - k));
         end else begin
            rem_ff[k]  <= rem_prev;
            root_ff[k] <= root_prev;
         end
      end
   end

   assign len_in = {1'b0, root_ff[RootWidth-1]}
                 + LenWidth'(rem_ff[RootWidth-1] > SqWidth'(root_ff[RootWidth-1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_o_ff <= 1'b0;
      end else begin
         vld_o_ff <= vld_ff[RootWidth-1];
      end
   end

   always_ff @(posedge clock) begin
      ctx_o_ff <= ctx_ff[RootWidth-1];
      len_ff   <= len_in;
   end

   assign out_valid  = vld_o_ff;
   assign out_ctx    = ctx_o_ff;
   assign out_len    = len_ff;
   assign twice_root = 34'(root_ff[RootWidth-1]) << 1;

   `QALU_ASSERT(a_root_remainder, !vld_ff[RootWidth-1] || (34'(rem_ff[RootWidth-1]) <= twice_root), "sqrt remainder above twice the root")

endmodule

`default_nettype wire

[sv/qalu_div.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU divider
// Operand setup with rounding offset, four restoring divider lanes with one
// quotient bit per stage, and the final saturation and result select.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  qalu_pkg::qalu_ctx_type in_ctx,
   input  logic [qalu_pkg::LenWidth-1:0] in_len,
   output logic                   out_valid,
   output qalu_pkg::qalu_rsp_type out_rsp
);
   import qalu_pkg::*;

   // setup
   logic [NrmWidth-1:0]  nrm;
   logic [NrmWidth-1:0]  dsr;
   logic signed [16:0]   v [4];
   logic [16:0]          mag [4];
   logic [NumWidth-1:0]  num_in [4];
   logic [3:0]           neg_in;
   logic                 use_in;
   qalu_rsp_type         res_in;
   logic [CompWidth-1:0] sp_in [4];

   logic                vld_p_ff;
   logic                use_p_ff;
   qalu_rsp_type        res_p_ff;
   logic [3:0]          neg_p_ff;
   logic [DenWidth-1:0] den_p_ff;
   logic [NumWidth-1:0] num_p_ff [4];

   // divider stages
   logic                vld_d_ff [NumWidth];
   logic                use_d_ff [NumWidth];
   qalu_rsp_type        res_d_ff [NumWidth];
   logic [3:0]          neg_d_ff [NumWidth];
   logic [DenWidth-1:0] den_d_ff [NumWidth];
   logic [DenWidth-1:0] rem_d_ff [NumWidth][4];
   logic [NumWidth-1:0] nq_d_ff  [NumWidth][4];

   // output
   logic                 vld_o_ff;
   qalu_rsp_type         rsp_ff, rsp_in;
   logic [NumWidth-1:0]  q [4];
   logic [CompWidth-1:0] qs [4];

   always_comb begin
      nrm = NrmWidth'((34'(in_ctx.sumsq) + 34'd2048) >> Frac);
      dsr = (in_ctx.op == OP_NORMALIZE) ? NrmWidth'(in_len) : nrm;
      for (int i = 0; i < 4; i++) begin
         if (in_ctx.op == OP_INVERSE && i != 0) begin
            v[i] = -17'($signed(in_ctx.a[i]));
         end else begin
            v[i] = 17'($signed(in_ctx.a[i]));
         end
         neg_in[i] = v[i] < 0;
         mag[i]    = neg_in[i] ? 17'(-v[i]) : 17'(v[i]);
         num_in[i] = {mag[i][15:0], 13'b0} + NumWidth'(dsr);
         if (v[i] > 0) begin
            sp_in[i] = SatMax;
         end else if (v[i] < 0) begin
            sp_in[i] = SatMin;
         end else begin
            sp_in[i] = '0;
         end
      end

      res_in = in_ctx.res;
      use_in = 1'b0;
      unique case (in_ctx.op)
         OP_LENGTH: begin
            res_in.r_w = (in_len > LenWidth'(32767)) ? SatMax : in_len[CompWidth-1:0];
         end
         OP_NORMALIZE: begin
            if (in_len == '0) begin
               res_in.r_w = OneQ;
            end else begin
               use_in = 1'b1;
            end
         end
         OP_INVERSE: begin
            if (in_ctx.sumsq == '0) begin
               res_in.zero_norm_error = 1'b1;
            end else if (nrm == '0) begin
               res_in.r_w = sp_in[0];
               res_in.r_x = sp_in[1];
               res_in.r_y = sp_in[2];
               res_in.r_z = sp_in[3];
            end else begin
               use_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
      end else begin
         vld_p_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      use_p_ff <= use_in;
      res_p_ff <= res_in;
      neg_p_ff <= neg_in;
      den_p_ff <= {dsr, 1'b0};
      for (int i = 0; i < 4; i++) begin
         num_p_ff[i] <= num_in[i];
      end
   end

   for (genvar k = 0; k < NumWidth; k++) begin : g_bit
      logic                vld_prev;
      logic                use_prev;
      qalu_rsp_type        res_prev;
      logic [3:0]          neg_prev;
      logic [DenWidth-1:0] den_prev;
      logic [DenWidth-1:0] rem_prev [4];
      logic [NumWidth-1:0] nq_prev  [4];
      logic [DenWidth:0]   trial    [4];

      if (k == 0) begin : g_first
         always_comb begin
            vld_prev = vld_p_ff;
            use_prev = use_p_ff;
            res_prev = res_p_ff;
            neg_prev = neg_p_ff;
            den_prev = den_p_ff;
            for (int l = 0; l < 4; l++) begin
               rem_prev[l] = '0;
               nq_prev[l]  = num_p_ff[l];
            end
         end
      end else begin : g_next
         always_comb begin
            vld_prev = vld_d_ff[k-1];
            use_prev = use_d_ff[k-1];
            res_prev = res_d_ff[k-1];
            neg_prev = neg_d_ff[k-1];
            den_prev = den_d_ff[k-1];
            for (int l = 0; l < 4; l++) begin
               rem_prev[l] = rem_d_ff[k-1][l];
               nq_prev[l]  = nq_d_ff[k-1][l];
            end
         end
      end

      always_comb begin
         for (int l = 0; l < 4; l++) begin
            trial[l] = {rem_prev[l], nq_prev[l][NumWidth-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_d_ff[k] <= 1'b0;
         end else begin
            vld_d_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         use_d_ff[k] <= use_prev;
         res_d_ff[k] <= res_prev;
         neg_d_ff[k] <= neg_prev;
         den_d_ff[k] <= den_prev;
         for (int l = 0; l < 4; l++) begin
            if (trial[l] >= {1'b0, den_prev}) begin
               rem_d_ff[k][l] <= DenWidth'(trial[l] - {1'b0, den_prev});
               nq_d_ff[k][l]  <= {nq_prev[l][NumWidth-2:0], 1'b1};
            end else begin
               rem_d_ff[k][l] <= trial[l][DenWidth-1:0];
               nq_d_ff[k][l]  <= {nq_prev[l][NumWidth-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         q[l] = nq_d_ff[NumWidth-1][l];
         if (neg_d_ff[NumWidth-1][l]) begin
            qs[l] = (q[l] > NumWidth'(32768)) ? SatMin : CompWidth'(16'h0 - q[l][CompWidth-1:0]);
         end else begin
            qs[l] = (q[l] > NumWidth'(32767)) ? SatMax : q[l][CompWidth-1:0];
         end
      end
      rsp_in = res_d_ff[NumWidth-1];
      if (use_d_ff[NumWidth-1]) begin
         rsp_in.r_w = qs[0];
         rsp_in.r_x = qs[1];
         rsp_in.r_y = qs[2];
         rsp_in.r_z = qs[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_o_ff <= 1'b0;
      end else begin
         vld_o_ff <= vld_d_ff[NumWidth-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = vld_o_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

[bench/tb_quaternion_alu.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU testbench
// Sends directed and random requests with random bursts and gaps, predicts
// every response with an independent Q4.12 model and compares field by field.
// Epsilon is reprogrammed over the CSR port between idle phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_alu;
   timeunit 1ns;
   timeprecision 1ps;

   import qalu_pkg::*;

   localparam int Latency    = 52;
   localparam int CycleLimit = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   qalu_req_type req_data = '0;
   logic         rsp_strobe;
   qalu_rsp_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   qalu_req_type pending_reqs[$];
   qalu_rsp_type expected_rsps[$];
   logic [14:0]  model_epsilon = EpsilonReset;
   int           error_count = 0;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           gap_left = 0;

   quaternion_alu dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) begin
         return 16'h7fff;
      end else if (v < -32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   // round 24 to 12 fraction bits, tie toward +inf
   function automatic longint round_q(longint v);
      return (v + 2048) >>> 12;
   endfunction

   function automatic longint root_nearest(longint x);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= x) begin
         r = r + 1;
         if (r * r < x / 4 && r > 2) r = r * 2 - 1;
      end
      while (r * r > x) r = r - 1;
      return (x - r * r > r) ? r + 1 : r;
   endfunction

   // rounded half away from zero, d > 0
   function automatic longint div_away(longint n, longint d);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   function automatic qalu_rsp_type quat_result(qalu_req_type q, logic [14:0] eps);
      longint a[4], b[4], r[4], s, ss, nn, ll, v, d;
      qalu_rsp_type res;
      a[0] = q.a_w; a[1] = q.a_x; a[2] = q.a_y; a[3] = q.a_z;
      b[0] = q.b_w; b[1] = q.b_x; b[2] = q.b_y; b[3] = q.b_z;
      s = q.scale_factor;
      for (int i = 0; i < 4; i++) r[i] = 0;
      res = '0;
      ss = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
      nn = (ss >> 12) + (((ss & 4095) >= 2048) ? 1 : 0);
      case (q.req_type)
         OP_MUL: begin
            r[0] = round_q(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
            r[1] = round_q(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
            r[2] = round_q(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
            r[3] = round_q(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
         end
         OP_DOT:    r[0] = round_q(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]);
         OP_LENGTH: r[0] = root_nearest(ss);
         OP_NORM:   r[0] = nn;
         OP_NORMALIZE: begin
            ll = root_nearest(ss);
            if (ll == 0) begin
               r[0] = 4096;
            end else begin
               for (int i = 0; i < 4; i++) r[i] = div_away(a[i] * 4096, ll);
            end
         end
         OP_CONJUGATE: begin
            r[0] = a[0]; r[1] = -a[1]; r[2] = -a[2]; r[3] = -a[3];
         end
         OP_INVERSE: begin
            if (ss == 0) begin
               res.zero_norm_error = 1'b1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  v = (i == 0) ? a[i] : -a[i];
                  if (nn == 0) r[i] = (v > 0) ? 32767 : (v < 0) ? -32768 : 0;
                  else r[i] = div_away(v * 4096, nn);
               end
            end
         end
         OP_ADD:   for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
         OP_SUB:   for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
         OP_SCALE: for (int i = 0; i < 4; i++) r[i] = round_q(a[i] * s);
         OP_EQUAL: begin
            res.is_equal = 1'b1;
            for (int i = 0; i < 4; i++) begin
               d = a[i] - b[i];
               if (d < 0) d = -d;
               if (d > longint'(eps)) res.is_equal = 1'b0;
            end
         end
         default: ;
      endcase
      res.r_w = clamp16(r[0]);
      res.r_x = clamp16(r[1]);
      res.r_y = clamp16(r[2]);
      res.r_z = clamp16(r[3]);
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", field, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [15:0] random_comp();
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 16384) - 8192);
         2: return 16'($urandom_range(0, 8) - 4);
         3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom_range(0, 4096) - 2048);
      endcase
   endfunction

   function automatic qalu_req_type random_req();
      qalu_req_type q;
      q.req_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
      q.a_w = random_comp(); q.a_x = random_comp();
      q.a_y = random_comp(); q.a_z = random_comp();
      q.b_w = random_comp(); q.b_x = random_comp();
      q.b_y = random_comp(); q.b_z = random_comp();
      q.scale_factor = random_comp();
      if (q.req_type == OP_EQUAL && $urandom_range(0, 2) != 0) begin
         q.b_w = clamp16(longint'(q.a_w) + $urandom_range(0, 12) - 6);
         q.b_x = clamp16(longint'(q.a_x) + $urandom_range(0, 12) - 6);
         q.b_y = clamp16(longint'(q.a_y) + $urandom_range(0, 12) - 6);
         q.b_z = clamp16(longint'(q.a_z) + $urandom_range(0, 12) - 6);
      end
      return q;
   endfunction

   function automatic qalu_req_type make_req(qalu_op_type op, logic [15:0] aw, logic [15:0] ax,
         logic [15:0] ay, logic [15:0] az, logic [15:0] bv, logic [15:0] sf);
      qalu_req_type q;
      q.req_type = op;
      q.a_w = aw; q.a_x = ax; q.a_y = ay; q.a_z = az;
      q.b_w = bv; q.b_x = bv; q.b_y = bv; q.b_z = bv;
      q.scale_factor = sf;
      return q;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            start <= 1'b1;
            req_data <= pending_reqs.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      qalu_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && start && !busy) expected_rsps.push_back(quat_result(req_data, model_epsilon));
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.r_w != want.r_w) report_mismatch("r_w", rsp_data.r_w, want.r_w);
            if (rsp_data.r_x != want.r_x) report_mismatch("r_x", rsp_data.r_x, want.r_x);
            if (rsp_data.r_y != want.r_y) report_mismatch("r_y", rsp_data.r_y, want.r_y);
            if (rsp_data.r_z != want.r_z) report_mismatch("r_z", rsp_data.r_z, want.r_z);
            if (rsp_data.is_equal != want.is_equal)
               report_mismatch("is_equal", rsp_data.is_equal, want.is_equal);
            if (rsp_data.zero_norm_error != want.zero_norm_error)
               report_mismatch("zero_norm_error", rsp_data.zero_norm_error,
                               want.zero_norm_error);
         end
      end
      if (cycle_count >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_epsilon(logic [14:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 3'(CsrEpsilon) * 3'd4; pwdata <= {17'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      model_epsilon = value;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
   endtask

   initial begin
      logic [14:0] eps_list[4];
      eps_list[0] = 15'd0; eps_list[1] = 15'h7fff;
      eps_list[2] = 15'($urandom); eps_list[3] = 15'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int op = 0; op <= 10; op++) begin
         pending_reqs.push_back(make_req(qalu_op_type'(op), 16'h8000, 16'h8000, 16'h8000,
                                         16'h8000, 16'h8000, 16'h8000));
         pending_reqs.push_back(make_req(qalu_op_type'(op), 16'h7fff, 16'h7fff, 16'h7fff,
                                         16'h7fff, 16'h8000, 16'h7fff));
      end
      // zero operand for normalize and inverse, tiny inverse, tie rounding, an unused opcode
      pending_reqs.push_back(make_req(OP_NORMALIZE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                      16'd0));
      pending_reqs.push_back(make_req(OP_INVERSE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(OP_INVERSE, 16'd1, 16'd0, 16'hffff, 16'd0, 16'd0,
                                      16'd0));
      pending_reqs.push_back(make_req(OP_SCALE, 16'h0800, 16'hf800, 16'd1, 16'hffff, 16'd0,
                                      16'h0800));
      pending_reqs.push_back(make_req(qalu_op_type'(4'd15), 16'd5, 16'd5, 16'd5, 16'd5, 16'd5,
                                      16'd5));
      for (int i = 0; i < 170; i++) pending_reqs.push_back(random_req());
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_epsilon(eps_list[ph]);
         pending_reqs.push_back(make_req(OP_EQUAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                         16'h7fff, 16'd0));
         for (int i = 0; i < 165; i++) pending_reqs.push_back(random_req());
         drain();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/qalu_pkg.sv
sv/qalu_front.sv
sv/qalu_sqrt.sv
sv/qalu_div.sv
sv/quaternion_alu.sv
bench/tb_quaternion_alu.sv
